FILE: rtl/mhsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhsp_pkg: shared types and constants for the sixteen-point compass heading
// Angle format, CORDIC arctangent table, compass point bounds, side-band type.
// ----------------------------------------------------------------------------
package mhsp_pkg;

    localparam int CORDIC_STEPS = 23;
    localparam int PRE_SHIFT    = 24;
    localparam int DEG_FRAC     = 16;
    localparam int ZW           = 25;   // signed angle accumulator, Q9.16
    localparam int HW           = 25;   // unsigned placed heading, Q9.16
    localparam int HEAD_W       = 9;
    localparam int POINT_W      = 4;
    localparam int POINTS       = 16;

    localparam logic [HEAD_W-1:0] DEG_0   = 9'd0;
    localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
    localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
    localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
    localparam logic [HEAD_W-1:0] DEG_359 = 9'd359;
    localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

    localparam logic [HW-1:0] Q_45  = HW'(45  * (1 << DEG_FRAC));
    localparam logic [HW-1:0] Q_90  = HW'(90  * (1 << DEG_FRAC));
    localparam logic [HW-1:0] Q_180 = HW'(180 * (1 << DEG_FRAC));
    localparam logic [HW-1:0] Q_360 = HW'(360 * (1 << DEG_FRAC));

    localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
        25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
        25'sd115,     25'sd57,      25'sd29,     25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1
    };

    localparam logic [HEAD_W-1:0] POINT_UPPER [POINTS] = '{
        9'd11,  9'd34,  9'd56,  9'd79,  9'd101, 9'd124, 9'd146, 9'd169,
        9'd191, 9'd214, 9'd236, 9'd259, 9'd281, 9'd304, 9'd326, 9'd349
    };

    typedef struct packed {
        logic              fixed;      // axis case, heading known up front
        logic [HEAD_W-1:0] fixed_deg;
        logic              equal;      // |x| == |y|
        logic              x_neg;
        logic              y_neg;
    } side_t;

endpackage

FILE: rtl/mhsp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhsp_in_if: sample channel
// Valid/ready channel carrying one signed X/Y magnetometer sample per beat.
// ----------------------------------------------------------------------------
interface mhsp_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] field_x;
    logic signed [SAMPLE_BITS-1:0] field_y;

    modport source (output valid, output field_x, output field_y, input ready);
    modport sink   (input valid, input field_x, input field_y, output ready);
endinterface

FILE: rtl/mhsp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhsp_out_if: heading channel
// Valid/ready channel carrying one heading and compass point per beat.
// ----------------------------------------------------------------------------
interface mhsp_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] heading_deg;
    logic [3:0] direction_point;

    modport source (output valid, output heading_deg, output direction_point,
                    input ready);
    modport sink   (input valid, input heading_deg, input direction_point,
                    output ready);
endinterface

FILE: rtl/mhsp_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhsp_prep: sample front end
// Takes magnitudes, pre-scales them for the CORDIC and flags special cases.
// ----------------------------------------------------------------------------
module mhsp_prep
    import mhsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int W           = 42
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] field_x,
    input  logic signed [SAMPLE_BITS-1:0] field_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [W-1:0]           cx,
    output logic signed [W-1:0]           cy,
    output side_t                         side
);

    logic                 valid_reg;
    logic signed [W-1:0]  cx_reg, cx_next;
    logic signed [W-1:0]  cy_reg, cy_next;
    side_t                side_reg, side_next;
    logic signed [W-1:0]  xs, ys, ax, ay;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        xs = {{(W-SAMPLE_BITS){field_x[SAMPLE_BITS-1]}}, field_x};
        ys = {{(W-SAMPLE_BITS){field_y[SAMPLE_BITS-1]}}, field_y};
        ax = field_x[SAMPLE_BITS-1] ? -xs : xs;
        ay = field_y[SAMPLE_BITS-1] ? -ys : ys;
        cx_next = ax <<< PRE_SHIFT;
        cy_next = ay <<< PRE_SHIFT;
        side_next.x_neg = field_x[SAMPLE_BITS-1];
        side_next.y_neg = field_y[SAMPLE_BITS-1];
        side_next.equal = (ax == ay);
        side_next.fixed = 1'b0;
        side_next.fixed_deg = DEG_0;
        if (field_y == '0)
        begin
            side_next.fixed = 1'b1;
            side_next.fixed_deg = field_x[SAMPLE_BITS-1] ? DEG_180 : DEG_0;
        end
        else if (field_x == '0)
        begin
            side_next.fixed = 1'b1;
            side_next.fixed_deg = field_y[SAMPLE_BITS-1] ? DEG_270 : DEG_90;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign side      = side_reg;

endmodule

FILE: rtl/mhsp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhsp_cell: one CORDIC vectoring cell
// Rotates (cx, cy) toward the X axis by one table angle and passes it on.
// ----------------------------------------------------------------------------
module mhsp_cell
    import mhsp_pkg::*;
#(
    parameter int W    = 42,
    parameter int STEP = 0
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  cx_in,
    input  logic signed [W-1:0]  cy_in,
    input  logic signed [ZW-1:0] z_in,
    input  side_t                side_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  cx_out,
    output logic signed [W-1:0]  cy_out,
    output logic signed [ZW-1:0] z_out,
    output side_t                side_out
);

    logic                 valid_reg;
    logic signed [W-1:0]  cx_reg, cx_next;
    logic signed [W-1:0]  cy_reg, cy_next;
    logic signed [ZW-1:0] z_reg, z_next;
    side_t                side_reg;
    logic signed [W-1:0]  dx, dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx = cy_in >>> STEP;
        dy = cx_in >>> STEP;
        if (cy_in > 0)
        begin
            cx_next = cx_in + dx;
            cy_next = cy_in - dy;
            z_next  = z_in + ATAN_Q16[STEP];
        end
        else
        begin
            cx_next = cx_in - dx;
            cy_next = cy_in + dy;
            z_next  = z_in - ATAN_Q16[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign cx_out    = cx_reg;
    assign cy_out    = cy_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/mhsp_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhsp_finish: heading back end
// Places the angle in its quadrant, adds declination mod 360, picks the point.
// ----------------------------------------------------------------------------
module mhsp_finish
    import mhsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [HEAD_W-1:0]    decl,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [ZW-1:0] z_in,
    input  side_t                side_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HEAD_W-1:0]    heading_deg,
    output logic [POINT_W-1:0]   direction_point
);

    logic                 raw_valid_reg;
    logic [HEAD_W-1:0]    raw_reg, raw_next;
    logic                 raw_ready;
    logic                 out_valid_reg;
    logic [HEAD_W-1:0]    heading_reg, heading_next;
    logic [POINT_W-1:0]   point_reg, point_next;
    logic [HW-1:0]        ang, hq;
    logic [HEAD_W-1:0]    whole;
    logic [HEAD_W:0]      sum;
    logic [POINT_W:0]     cnt;

    assign raw_ready = !out_valid_reg || out_ready;
    assign in_ready  = !raw_valid_reg || raw_ready;

    // quadrant placement, truncation to whole degrees
    always_comb
    begin
        if (side_in.equal)
            ang = Q_45;
        else if (z_in[ZW-1])
            ang = '0;
        else if (HW'(z_in) > Q_90)
            ang = Q_90;
        else
            ang = HW'(z_in);
        if (!side_in.y_neg)
            hq = side_in.x_neg ? (Q_180 - ang) : ang;
        else
            hq = side_in.x_neg ? (Q_180 + ang) : (Q_360 - ang);
        whole = hq[HW-1:DEG_FRAC];
        if (side_in.fixed)
            raw_next = side_in.fixed_deg;
        else if (whole >= DEG_360)
            raw_next = DEG_359;
        else
            raw_next = whole;
    end

    // declination, mod 360, point lookup
    always_comb
    begin
        sum = {1'b0, raw_reg} + {1'b0, decl};
        if (sum >= {DEG_360, 1'b0})
            heading_next = HEAD_W'(sum - {DEG_360, 1'b0});
        else if (sum >= {1'b0, DEG_360})
            heading_next = HEAD_W'(sum - {1'b0, DEG_360});
        else
            heading_next = sum[HEAD_W-1:0];
        cnt = '0;
        for (int i = 0; i < POINTS; i++)
            cnt = cnt + {{POINT_W{1'b0}}, (heading_next > POINT_UPPER[i])};
        point_next = cnt[POINT_W-1:0];   // above the last bound wraps to N
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                raw_valid_reg <= in_valid;
            if (raw_ready)
                out_valid_reg <= raw_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            raw_reg <= raw_next;
        if (raw_valid_reg && raw_ready)
        begin
            heading_reg <= heading_next;
            point_reg   <= point_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign heading_deg     = heading_reg;
    assign direction_point = point_reg;

endmodule

FILE: rtl/magnetometer_heading_sixteen_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading_sixteen_point: sixteen-point compass heading
// Pipeline, in order from sample beat to heading beat: front end,
//   23 CORDIC cells, quadrant stage, output register.
// Throughput: one sample per cycle; each cell stalls only when full and
//   blocked downstream, so bubbles close up under back-pressure.
// Reset clears all valid flags and the declination register to 0.
// ----------------------------------------------------------------------------
module magnetometer_heading_sixteen_point
    import mhsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [HEAD_W-1:0] cfg_wdata,
    mhsp_in_if.sink           sample,
    mhsp_out_if.source        result
);

    localparam int W = SAMPLE_BITS + 26;

    logic [HEAD_W-1:0]    decl_reg;
    logic                 v_s    [0:CORDIC_STEPS];
    logic                 r_s    [0:CORDIC_STEPS];
    logic signed [W-1:0]  cx_s   [0:CORDIC_STEPS];
    logic signed [W-1:0]  cy_s   [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_s    [0:CORDIC_STEPS];
    side_t                side_s [0:CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= '0;
        else if (cfg_we)
            decl_reg <= cfg_wdata;
    end

    mhsp_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W           (W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .field_x   (sample.field_x),
        .field_y   (sample.field_y),
        .out_valid (v_s[0]),
        .out_ready (r_s[0]),
        .cx        (cx_s[0]),
        .cy        (cy_s[0]),
        .side      (side_s[0])
    );

    assign z_s[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        mhsp_cell #(
            .W    (W),
            .STEP (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_s[k]),
            .in_ready  (r_s[k]),
            .cx_in     (cx_s[k]),
            .cy_in     (cy_s[k]),
            .z_in      (z_s[k]),
            .side_in   (side_s[k]),
            .out_valid (v_s[k+1]),
            .out_ready (r_s[k+1]),
            .cx_out    (cx_s[k+1]),
            .cy_out    (cy_s[k+1]),
            .z_out     (z_s[k+1]),
            .side_out  (side_s[k+1])
        );
    end

    mhsp_finish u_finish (
        .clk             (clk),
        .rst_n           (rst_n),
        .decl            (decl_reg),
        .in_valid        (v_s[CORDIC_STEPS]),
        .in_ready        (r_s[CORDIC_STEPS]),
        .z_in            (z_s[CORDIC_STEPS]),
        .side_in         (side_s[CORDIC_STEPS]),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .heading_deg     (result.heading_deg),
        .direction_point (result.direction_point)
    );

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.heading_deg < DEG_360)
        else $error("heading out of range");

    a_north_low: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.heading_deg <= POINT_UPPER[0]
            || result.heading_deg > POINT_UPPER[POINTS-1])
        |-> result.direction_point == '0)
        else $error("north sector mismatch");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> result.valid && !result.ready)
        else $error("input stalled while output free");

    a_decl_write: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(cfg_we) |-> decl_reg == $past(cfg_wdata))
        else $error("declination write lost");

endmodule
